/* sv/tssw_pkg.sv */
//------------------------------------------------------------------------------
// tssw_pkg
// Shared types and constants of the triangle scanline span walker.
//------------------------------------------------------------------------------
package tssw_pkg;

    localparam int NUM_REGS = 6;

    localparam logic [2:0] REG_AX = 3'd0;
    localparam logic [2:0] REG_AY = 3'd1;
    localparam logic [2:0] REG_BX = 3'd2;
    localparam logic [2:0] REG_BY = 3'd3;
    localparam logic [2:0] REG_CX = 3'd4;
    localparam logic [2:0] REG_CY = 3'd5;

    typedef struct packed {
        logic restart;
    } tssw_req_t;

endpackage

/* sv/triangle_scanline_span_walker_top.sv */
//------------------------------------------------------------------------------
// triangle_scanline_span_walker_top
// Bresenham scanline triangle fill: returns one scanline span per request.
//------------------------------------------------------------------------------
// The three vertices are written through the APB port (registers a_x, a_y,
// b_x, b_y, c_x, c_y at byte addresses 0 to 20). A request with restart high
// latches and sorts them and returns the first span; restart low returns the
// next span, or once the walk has ended a span with span_valid low in the cycle
// after it is taken. Requests enter a two entry queue (push/full); spans
// leave through an output register (empty/pop). A taken request passes
// S_START, the walk of edge one (S_E1) and of the long edge (S_E2), and S_FIN
// registers the span. An edge takes its loop checks, error subtractions and x
// steps one after another, and leaving a steep edge is a step of its own. A
// restart adds sorting (S_SORT) and setup (S_SETUP), a flat top also passes
// S_LOWER, and the switch to the lower half passes S_LOWER before the next
// request is taken. The next request is taken only after the previous span
// is handed over. Reset clears the vertices to zero, ends any walk and empties
// both queues. While pop is low the finished span is held and the walker waits.
//------------------------------------------------------------------------------
module triangle_scanline_span_walker_top
    import tssw_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic                         restart,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] row,
    output logic signed [COORD_BITS-1:0] span_left,
    output logic signed [COORD_BITS-1:0] span_right,
    output logic                         span_valid,
    output logic                         last_span
);

    logic [COORD_BITS-1:0] cfg_reg [NUM_REGS];
    logic [2:0]            ridx;
    logic                  req_valid;
    logic                  req_take;
    tssw_req_t             req;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_REGS; k++)
            begin
                cfg_reg[k] <= '0;
            end
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                REG_AX, REG_AY, REG_BX, REG_BY, REG_CX, REG_CY:
                    cfg_reg[ridx] <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (ridx)
            REG_AX, REG_AY, REG_BX, REG_BY, REG_CX, REG_CY:
                prdata = 32'(cfg_reg[ridx]);
            default: prdata = '0;
        endcase
    end

    tssw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .restart   (restart),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take)
    );

    tssw_walker #(.CB(COORD_BITS)) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_reg    (cfg_reg),
        .req_valid  (req_valid),
        .req        (req),
        .req_take   (req_take),
        .empty      (empty),
        .pop        (pop),
        .row        (row),
        .span_left  (span_left),
        .span_right (span_right),
        .span_valid (span_valid),
        .last_span  (last_span)
    );

endmodule

/* sv/tssw_front.sv */
//------------------------------------------------------------------------------
// tssw_front
// Accepts step requests and holds them in a two entry queue for the walker.
//------------------------------------------------------------------------------
module tssw_front
    import tssw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  logic      restart,
    output logic      req_valid,
    output tssw_req_t req,
    input  logic      req_take
);

    tssw_req_t   slot_reg [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;
    logic        do_push;
    logic        do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = slot_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg].restart <= restart;
        end
    end

endmodule

/* sv/tssw_walker.sv */
//------------------------------------------------------------------------------
// tssw_walker
// Sorts the vertices and steps the two Bresenham edges one move per cycle.
//------------------------------------------------------------------------------
module tssw_walker
    import tssw_pkg::*;
#(
    parameter int CB = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CB-1:0]        cfg_reg [NUM_REGS],
    input  logic                 req_valid,
    input  tssw_req_t            req,
    output logic                 req_take,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [CB-1:0] row,
    output logic signed [CB-1:0] span_left,
    output logic signed [CB-1:0] span_right,
    output logic                 span_valid,
    output logic                 last_span
);

    localparam int W = CB + 3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SORT  = 8'b00000010,
        S_SETUP = 8'b00000100,
        S_START = 8'b00001000,
        S_E1    = 8'b00010000,
        S_E2    = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_LOWER = 8'b10000000
    } st_t;

    st_t                st_reg, st_next;
    logic signed [W-1:0] vx_reg [3];
    logic signed [W-1:0] vy_reg [3];
    logic [1:0]          sort_reg;
    logic signed [W-1:0] x1_reg, x2_reg, row_reg, lo_reg, hi_reg;
    logic signed [W-1:0] e1_reg, e2_reg, d1_reg, n1_reg, d2_reg, n2_reg;
    logic signed [W-1:0] i_reg;
    logic                neg1_reg, neg2_reg, sw1_reg, sw2_reg;
    logic signed [W-1:0] p1_reg, p2_reg;
    logic                inner1_reg, inner2_reg;
    logic [1:0]          phase_reg;
    logic                outv_reg;
    logic signed [CB-1:0] orow_reg, olo_reg, ohi_reg;
    logic                ovalid_reg, olast_reg;

    logic signed [W-1:0] s1, s2, ldx, ldy, dx1, dy1, dx2, dy2;
    logic signed [W-1:0] e1n, e2n;
    logic                upper;

    assign s1    = neg1_reg ? -W'(1) : W'(1);
    assign s2    = neg2_reg ? -W'(1) : W'(1);
    assign upper = (phase_reg == 2'd1);
    assign e1n   = e1_reg + n1_reg;
    assign e2n   = e2_reg + n2_reg;

    assign dx1 = vx_reg[1] - vx_reg[0];
    assign dy1 = vy_reg[1] - vy_reg[0];
    assign dx2 = vx_reg[2] - vx_reg[0];
    assign dy2 = vy_reg[2] - vy_reg[0];
    assign ldx = vx_reg[2] - vx_reg[1];
    assign ldy = vy_reg[2] - vy_reg[1];

    assign req_take   = (st_reg == S_IDLE) && !outv_reg && req_valid;
    assign empty      = !outv_reg;
    assign row        = orow_reg;
    assign span_left  = olo_reg;
    assign span_right = ohi_reg;
    assign span_valid = ovalid_reg;
    assign last_span  = olast_reg;

    function automatic logic signed [W-1:0] absv(input logic signed [W-1:0] v);
        return v[W-1] ? -v : v;
    endfunction

    function automatic logic signed [W-1:0] smin(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [W-1:0] smax(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  st_next = st_reg;
            S_SORT:  st_next = (sort_reg == 2'd2) ? S_SETUP : S_SORT;
            S_SETUP: st_next = S_START;
            default: st_next = st_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            phase_reg  <= 2'd0;
            outv_reg   <= 1'b0;
            sort_reg   <= 2'd0;
            for (int k = 0; k < 3; k++)
            begin
                vx_reg[k] <= '0;
                vy_reg[k] <= '0;
            end
            {x1_reg, x2_reg, row_reg, lo_reg, hi_reg} <= '0;
            {e1_reg, e2_reg, d1_reg, n1_reg, d2_reg, n2_reg, i_reg} <= '0;
            {neg1_reg, neg2_reg, sw1_reg, sw2_reg} <= '0;
            {p1_reg, p2_reg} <= '0;
            {inner1_reg, inner2_reg} <= '0;
            {orow_reg, olo_reg, ohi_reg, ovalid_reg, olast_reg} <= '0;
        end
        else
        begin
            if (outv_reg && pop)
            begin
                outv_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        if (req.restart)
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                vx_reg[k] <= W'(signed'(cfg_reg[2*k]));
                                vy_reg[k] <= W'(signed'(cfg_reg[2*k+1]));
                            end
                            sort_reg <= 2'd0;
                            st_reg   <= S_SORT;
                        end
                        else if (phase_reg == 2'd0)
                        begin
                            {orow_reg, olo_reg, ohi_reg, ovalid_reg, olast_reg} <= '0;
                            outv_reg <= 1'b1;
                        end
                        else
                        begin
                            st_reg <= S_START;
                        end
                    end
                end
                S_SORT:
                begin
                    sort_reg <= sort_reg + 2'd1;
                    if (sort_reg == 2'd0 && vy_reg[0] > vy_reg[1])
                    begin
                        vx_reg[0] <= vx_reg[1]; vx_reg[1] <= vx_reg[0];
                        vy_reg[0] <= vy_reg[1]; vy_reg[1] <= vy_reg[0];
                    end
                    if (sort_reg == 2'd1 && vy_reg[0] > vy_reg[2])
                    begin
                        vx_reg[0] <= vx_reg[2]; vx_reg[2] <= vx_reg[0];
                        vy_reg[0] <= vy_reg[2]; vy_reg[2] <= vy_reg[0];
                    end
                    if (sort_reg == 2'd2 && vy_reg[1] > vy_reg[2])
                    begin
                        vx_reg[1] <= vx_reg[2]; vx_reg[2] <= vx_reg[1];
                        vy_reg[1] <= vy_reg[2]; vy_reg[2] <= vy_reg[1];
                    end
                    st_reg <= st_next;
                end
                S_SETUP:
                begin
                    x1_reg  <= vx_reg[0];
                    x2_reg  <= vx_reg[0];
                    row_reg <= vy_reg[0];
                    neg2_reg <= dx2[W-1];
                    sw2_reg  <= (dy2 > absv(dx2));
                    d2_reg   <= (dy2 > absv(dx2)) ? dy2 : absv(dx2);
                    n2_reg   <= (dy2 > absv(dx2)) ? absv(dx2) : dy2;
                    e2_reg   <= ((dy2 > absv(dx2)) ? dy2 : absv(dx2)) >>> 1;
                    i_reg    <= '0;
                    if (vy_reg[0] == vy_reg[1])
                    begin
                        phase_reg <= 2'd2;
                        st_reg    <= S_LOWER;
                    end
                    else
                    begin
                        neg1_reg  <= dx1[W-1];
                        sw1_reg   <= (dy1 > absv(dx1));
                        d1_reg    <= (dy1 > absv(dx1)) ? dy1 : absv(dx1);
                        n1_reg    <= (dy1 > absv(dx1)) ? absv(dx1) : dy1;
                        e1_reg    <= ((dy1 > absv(dx1)) ? dy1 : absv(dx1)) >>> 1;
                        phase_reg <= 2'd1;
                        st_reg    <= st_next;
                    end
                end
                S_LOWER:
                begin
                    // A flat top walks on at once; from the upper half the next
                    // request is awaited.
                    neg1_reg  <= ldx[W-1];
                    sw1_reg   <= (ldy > absv(ldx));
                    d1_reg    <= (ldy > absv(ldx)) ? ldy : absv(ldx);
                    n1_reg    <= (ldy > absv(ldx)) ? absv(ldx) : ldy;
                    e1_reg    <= ((ldy > absv(ldx)) ? ldy : absv(ldx)) >>> 1;
                    x1_reg    <= vx_reg[1];
                    i_reg     <= '0;
                    phase_reg <= 2'd2;
                    st_reg    <= (phase_reg == 2'd2) ? S_START : S_IDLE;
                end
                S_START:
                begin
                    lo_reg     <= smin(x1_reg, x2_reg);
                    hi_reg     <= smax(x1_reg, x2_reg);
                    p1_reg     <= '0;
                    p2_reg     <= '0;
                    inner1_reg <= 1'b0;
                    st_reg     <= S_E1;
                end
                S_E1:
                begin
                    // One outer or inner iteration of the edge one loop per cycle.
                    if (!inner1_reg)
                    begin
                        if (!(i_reg < d1_reg))
                        begin
                            st_reg     <= S_E2;
                            inner2_reg <= 1'b0;
                        end
                        else
                        begin
                            if (upper)
                            begin
                                i_reg <= i_reg + W'(1);
                            end
                            e1_reg     <= e1n;
                            inner1_reg <= 1'b1;
                        end
                    end
                    else if (e1_reg >= d1_reg)
                    begin
                        e1_reg <= e1_reg - d1_reg;
                        if (sw1_reg)
                        begin
                            p1_reg <= s1;
                            if (!upper)
                            begin
                                st_reg <= S_E2; inner2_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            st_reg <= S_E2; inner2_reg <= 1'b0;
                        end
                    end
                    else if (sw1_reg)
                    begin
                        st_reg <= S_E2; inner2_reg <= 1'b0;
                    end
                    else
                    begin
                        x1_reg     <= x1_reg + s1;
                        lo_reg     <= smin(lo_reg, x1_reg + s1);
                        hi_reg     <= smax(hi_reg, x1_reg + s1);
                        inner1_reg <= 1'b0;
                        if (!upper && (i_reg < d1_reg))
                        begin
                            i_reg <= i_reg + W'(1);
                        end
                    end
                end
                S_E2:
                begin
                    if (!inner2_reg)
                    begin
                        if (!upper && x2_reg == vx_reg[2])
                        begin
                            st_reg <= S_FIN;
                        end
                        else
                        begin
                            e2_reg     <= e2n;
                            inner2_reg <= 1'b1;
                        end
                    end
                    else if (e2_reg >= d2_reg)
                    begin
                        e2_reg <= e2_reg - d2_reg;
                        if (sw2_reg)
                        begin
                            p2_reg <= s2;
                        end
                        else
                        begin
                            st_reg <= S_FIN;
                        end
                    end
                    else if (sw2_reg)
                    begin
                        st_reg <= S_FIN;
                    end
                    else
                    begin
                        x2_reg     <= x2_reg + s2;
                        lo_reg     <= smin(lo_reg, x2_reg + s2);
                        hi_reg     <= smax(hi_reg, x2_reg + s2);
                        inner2_reg <= 1'b0;
                    end
                end
                S_FIN:
                begin
                    if (!outv_reg)
                    begin
                        orow_reg   <= CB'(row_reg);
                        olo_reg    <= CB'(lo_reg);
                        ohi_reg    <= CB'(hi_reg);
                        ovalid_reg <= 1'b1;
                        outv_reg   <= 1'b1;
                        x1_reg  <= x1_reg + (sw1_reg ? W'(0) : s1) + p1_reg;
                        x2_reg  <= x2_reg + (sw2_reg ? W'(0) : s2) + p2_reg;
                        row_reg <= row_reg + W'(1);
                        if (upper)
                        begin
                            olast_reg <= 1'b0;
                            st_reg    <= (row_reg + W'(1) == vy_reg[1] || !(i_reg < d1_reg))
                                         ? S_LOWER : S_IDLE;
                        end
                        else if (row_reg + W'(1) > vy_reg[2])
                        begin
                            olast_reg <= 1'b1;
                            phase_reg <= 2'd0;
                            st_reg    <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + W'(1);
                            olast_reg <= (i_reg + W'(1) > d1_reg);
                            if (i_reg + W'(1) > d1_reg)
                            begin
                                phase_reg <= 2'd0;
                            end
                            st_reg    <= S_IDLE;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* bench/triangle_scanline_span_walker_top_tb.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// triangle_scanline_span_walker_top_tb
// Self-checking bench for the scanline span walker: triangles are programmed
// over APB and walked span by span. Every returned span is compared with a
// built-in Bresenham predictor, under random stalls on both sides.
//------------------------------------------------------------------------------
module triangle_scanline_span_walker_top_tb
    import tssw_pkg::*;
;

    localparam int  CB        = 12;
    localparam int  CYCLE_CAP = 60_000_000;
    localparam int  N_ITEMS   = 700;

    typedef enum int {WALK_IDLE, WALK_UPPER, WALK_LOWER} walk_phase_t;

    typedef struct packed {
        logic [CB-1:0] row;
        logic [CB-1:0] left;
        logic [CB-1:0] right;
        logic          valid;
        logic          last;
    } span_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              push;
    logic              full;
    logic              restart;
    logic              empty;
    logic              pop;
    logic signed [CB-1:0] row;
    logic signed [CB-1:0] span_left;
    logic signed [CB-1:0] span_right;
    logic              span_valid;
    logic              last_span;

    triangle_scanline_span_walker_top #(.COORD_BITS(CB)) uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .restart(restart), .empty(empty), .pop(pop),
        .row(row), .span_left(span_left), .span_right(span_right),
        .span_valid(span_valid), .last_span(last_span)
    );

    span_t       pending_spans[$];
    int          errors;
    int          items_sent;
    int          spans_seen;
    int          triangles;
    int          cycle_count;
    bit          quiet;
    int          long_hold;

    logic signed [CB-1:0] vert_reg[6];
    int          vtx[6];
    int          e1x;
    int          e2x;
    int          cur_row;
    int          err[2];
    int          dl[4];
    bit          neg1;
    bit          neg2;
    bit          swp1;
    bit          swp2;
    int          step_i;
    walk_phase_t phase;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("** triangle_scanline_span_walker_top: FAILED **");
            $finish;
        end
    end

    function automatic void setup_edge(int k, int xa, int ya, int xb, int yb);
        int dx;
        int dy;
        int t;
        bit ng;
        bit sw;
        dx = xb - xa;
        dy = yb - ya;
        ng = 0;
        sw = 0;
        if (dx < 0)
        begin
            dx = -dx;
            ng = 1;
        end
        if (dy > dx)
        begin
            t = dx;
            dx = dy;
            dy = t;
            sw = 1;
        end
        if (k == 0)
        begin
            neg1 = ng;
            swp1 = sw;
        end
        else
        begin
            neg2 = ng;
            swp2 = sw;
        end
        dl[2*k] = dx;
        dl[2*k+1] = dy;
    endfunction

    function automatic void begin_lower();
        setup_edge(0, vtx[2], vtx[3], vtx[4], vtx[5]);
        e1x = vtx[2];
        err[0] = dl[0] / 2;
        step_i = 0;
        phase = WALK_LOWER;
    endfunction

    function automatic void swap_vtx(int p, int q);
        int t;
        t = vtx[2*p];   vtx[2*p] = vtx[2*q];     vtx[2*q] = t;
        t = vtx[2*p+1]; vtx[2*p+1] = vtx[2*q+1]; vtx[2*q+1] = t;
    endfunction

    function automatic void latch_triangle();
        for (int n = 0; n < 6; n++)
            vtx[n] = vert_reg[n];
        if (vtx[1] > vtx[3]) swap_vtx(0, 1);
        if (vtx[1] > vtx[5]) swap_vtx(0, 2);
        if (vtx[3] > vtx[5]) swap_vtx(1, 2);
        e1x = vtx[0];
        e2x = vtx[0];
        cur_row = vtx[1];
        setup_edge(0, vtx[0], vtx[1], vtx[2], vtx[3]);
        setup_edge(1, vtx[0], vtx[1], vtx[4], vtx[5]);
        err[1] = dl[2] / 2;
        if (vtx[1] == vtx[3])
            begin_lower();
        else
        begin
            err[0] = dl[0] / 2;
            step_i = 0;
            phase = WALK_UPPER;
        end
    endfunction

    function automatic void advance_long_edge(bit stop_at_end, inout int p2);
        int  s2;
        bit  jump;
        s2 = neg2 ? -1 : 1;
        forever
        begin
            jump = 0;
            if (stop_at_end && e2x == vtx[4]) return;
            err[1] += dl[3];
            while (err[1] >= dl[2])
            begin
                err[1] -= dl[2];
                if (swp2) p2 = s2;
                else
                begin
                    jump = 1;
                    break;
                end
            end
            if (jump || swp2) return;
            e2x += s2;
        end
    endfunction

    function automatic span_t predict_span(bit rs);
        span_t r;
        int    lo;
        int    hi;
        int    s1;
        int    s2;
        int    p1;
        int    p2;
        int    i;
        int    rw;
        bit    upper;
        bit    jump;
        bit    fin;
        r = '0;
        if (rs) latch_triangle();
        if (phase == WALK_IDLE) return r;
        s1 = neg1 ? -1 : 1;
        s2 = neg2 ? -1 : 1;
        upper = (phase == WALK_UPPER);
        p1 = 0;
        p2 = 0;
        i = step_i;
        fin = 0;
        lo = (e1x < e2x) ? e1x : e2x;
        hi = (e1x < e2x) ? e2x : e1x;
        while (i < dl[0])
        begin
            jump = 0;
            if (upper) i++;
            err[0] += dl[1];
            while (err[0] >= dl[0])
            begin
                err[0] -= dl[0];
                if (swp1)
                begin
                    p1 = s1;
                    if (!upper) break;
                end
                else
                begin
                    jump = 1;
                    break;
                end
            end
            if (jump || swp1) break;
            e1x += s1;
            if (!upper && i < dl[0]) i++;
        end
        advance_long_edge(!upper, p2);
        if (lo > e1x) lo = e1x;
        if (lo > e2x) lo = e2x;
        if (hi < e1x) hi = e1x;
        if (hi < e2x) hi = e2x;
        rw = cur_row;
        if (!swp1) e1x += s1;
        e1x += p1;
        if (!swp2) e2x += s2;
        e2x += p2;
        cur_row += 1;
        step_i = i;
        if (upper)
        begin
            if (cur_row == vtx[3] || !(i < dl[0])) begin_lower();
        end
        else if (cur_row > vtx[5])
            fin = 1;
        else
        begin
            step_i = i + 1;
            if (step_i > dl[0]) fin = 1;
        end
        if (fin) phase = WALK_IDLE;
        r.row = rw[CB-1:0];
        r.left = lo[CB-1:0];
        r.right = hi[CB-1:0];
        r.valid = 1'b1;
        r.last = fin;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            spans_seen++;
            if (pending_spans.size() == 0)
            begin
                $error("span with no request outstanding: row %0d", row);
                errors++;
            end
            else
            begin
                span_t e;
                e = pending_spans.pop_front();
                if (row !== e.row)
                begin
                    $error("row: expected %0d, got %0d", $signed(e.row), row);
                    errors++;
                end
                if (span_left !== e.left)
                begin
                    $error("span_left: expected %0d, got %0d", $signed(e.left), span_left);
                    errors++;
                end
                if (span_right !== e.right)
                begin
                    $error("span_right: expected %0d, got %0d", $signed(e.right), span_right);
                    errors++;
                end
                if (span_valid !== e.valid)
                begin
                    $error("span_valid: expected %0b, got %0b", e.valid, span_valid);
                    errors++;
                end
                if (last_span !== e.last)
                begin
                    $error("last_span: expected %0b, got %0b", e.last, last_span);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (long_hold > 0)
        begin
            pop <= 1'b0;
            long_hold <= long_hold - 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            pop <= 1'b0;
            long_hold <= $urandom_range(0, 7);
        end
        else
            pop <= 1'b1;
    end

    task automatic send_step(bit rs);
        span_t exp_span;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            push = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
        else
            @(negedge clk);
        push = 1'b1;
        restart = rs;
        do @(posedge clk); while (full);
        exp_span = predict_span(rs);
        pending_spans = {pending_spans, exp_span};
        items_sent++;
    endtask

    task automatic go_quiet_push();
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic drain();
        go_quiet_push();
        while (pending_spans.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_vertex(logic [2:0] idx, int value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        vert_reg[idx] = value[CB-1:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic walk_triangle(int ax, int ay, int bx, int by, int cx, int cy,
                                 int max_steps);
        int n;
        drain();
        write_vertex(REG_AX, ax);
        write_vertex(REG_AY, ay);
        write_vertex(REG_BX, bx);
        write_vertex(REG_BY, by);
        write_vertex(REG_CX, cx);
        write_vertex(REG_CY, cy);
        triangles++;
        send_step(1'b1);
        n = 1;
        while (phase != WALK_IDLE && n < max_steps)
        begin
            send_step(1'b0);
            n++;
        end
    endtask

    task automatic test_idle_after_reset();
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
    endtask

    task automatic test_degenerate_shapes();
        walk_triangle(-3, 5, 7, 5, 2, 5, 4);
        send_step(1'b0);
        walk_triangle(9, -9, 9, -9, 9, -9, 4);
    endtask

    task automatic test_flat_and_steep();
        walk_triangle(0, 0, 6, 0, 3, 4, 8);
        walk_triangle(2, -4, -5, 2, 6, 2, 9);
        walk_triangle(0, 0, 1, 7, -1, 9, 12);
    endtask

    task automatic test_extreme_coordinates();
        walk_triangle(-2048, -2048, 2047, -2047, 0, 2047, 3);
        walk_triangle(2047, 2047, -2048, 2046, -2048, 2047, 3);
    endtask

    task automatic test_backpressure();
        drain();
        long_hold = 400;
        send_step(1'b1);
        repeat (6) send_step(1'b0);
        drain();
    endtask

    task automatic test_random_walks();
        int cxo;
        int cyo;
        int v[6];
        int cap;
        while (items_sent < N_ITEMS)
        begin
            if (items_sent > N_ITEMS - 100) quiet = 1;
            if ($urandom_range(0, 6) == 0)
            begin
                foreach (v[k]) v[k] = $urandom_range(0, 4095) - 2048;
                cap = 20;
            end
            else
            begin
                cxo = $urandom_range(0, 4000) - 2000;
                cyo = $urandom_range(0, 4000) - 2000;
                for (int k = 0; k < 3; k++)
                begin
                    v[2*k] = cxo + $urandom_range(0, 30) - 15;
                    v[2*k+1] = cyo + $urandom_range(0, 24) - 12;
                end
                cap = 60;
            end
            walk_triangle(v[0], v[1], v[2], v[3], v[4], v[5], cap);
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 3)) send_step(1'b0);
                1: repeat ($urandom_range(1, 4)) send_step($urandom_range(0, 1));
                default: ;
            endcase
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        restart = 1'b0;
        errors = 0;
        items_sent = 0;
        spans_seen = 0;
        triangles = 0;
        cycle_count = 0;
        quiet = 0;
        long_hold = 0;
        foreach (vert_reg[k]) vert_reg[k] = '0;
        foreach (vtx[k]) vtx[k] = 0;
        e1x = 0; e2x = 0; cur_row = 0;
        err[0] = 0; err[1] = 0;
        foreach (dl[k]) dl[k] = 0;
        neg1 = 0; neg2 = 0; swp1 = 0; swp2 = 0;
        step_i = 0;
        phase = WALK_IDLE;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_after_reset();
        test_degenerate_shapes();
        test_flat_and_steep();
        test_extreme_coordinates();
        test_backpressure();
        test_random_walks();

        drain();
        repeat (50) @(posedge clk);
        $display("Covered %0d step requests over %0d triangles, %0d spans checked,",
                 items_sent, triangles, spans_seen);
        $display("including degenerate, flat, extreme and back-pressured walks.");
        if (errors == 0)
            $display("** triangle_scanline_span_walker_top: PASSED **");
        else
            $display("** triangle_scanline_span_walker_top: FAILED **");
        $finish;
    end

endmodule

/* triangle_scanline_span_walker_top.f */
sv/tssw_pkg.sv
sv/tssw_front.sv
sv/tssw_walker.sv
sv/triangle_scanline_span_walker_top.sv
bench/triangle_scanline_span_walker_top_tb.sv
